// ===== sv/sequenced_history_ring_top_macros.svh =====
// assertion macros for the sequenced history ring
// expects signals named clock and reset in the module that uses them
`ifndef SEQUENCED_HISTORY_RING_TOP_MACROS_SVH
`define SEQUENCED_HISTORY_RING_TOP_MACROS_SVH

// property checked on every clock edge outside reset
`define SHR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define SHR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/shr_pkg.sv =====
// shared types for the sequenced history ring
// no dependencies
package shr_pkg;

   typedef enum logic [0:0] {
      REQ_RECORD = 1'b0,
      REQ_READ   = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic [31:0] entry_seq;
      logic [31:0] entry_time;
      logic [5:0]  entry_pos;
      logic [6:0]  run_length;
      logic [6:0]  run_start;
      logic [6:0]  fill_count;
      logic [5:0]  write_slot;
      logic        is_last;
      logic        is_empty;
   } rsp_type;

endpackage

// ===== sv/shr_mem.sv =====
// point store: sequence number and timestamp per slot, one write and one read port
// read data registered, held while no read is issued; no package dependency
module shr_mem #(
   parameter int DEPTH     = 64,
   parameter int TIME_BITS = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [31:0]              wr_seq,
   input  logic [TIME_BITS-1:0]     wr_time,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [31:0]              rd_seq,
   output logic [TIME_BITS-1:0]     rd_time
);

   logic [31:0]          seq_mem [DEPTH];
   logic [TIME_BITS-1:0] time_mem [DEPTH];
   logic [31:0]          rd_seq_ff;
   logic [TIME_BITS-1:0] rd_time_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         seq_mem[wr_addr]  <= wr_seq;
         time_mem[wr_addr] <= wr_time;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_seq_ff  <= seq_mem[rd_addr];
         rd_time_ff <= time_mem[rd_addr];
      end
   end

   assign rd_seq  = rd_seq_ff;
   assign rd_time = rd_time_ff;

endmodule

// ===== sv/shr_ctrl.sv =====
// sequencer: record writes, read scan and run emission over the point store
// depends on shr_pkg and sequenced_history_ring_top_macros.svh
`include "sequenced_history_ring_top_macros.svh"

module shr_ctrl #(
   parameter int DEPTH     = 64,
   parameter int TIME_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_kind,
   input  logic [31:0]              req_time,
   input  logic [31:0]              req_seq,
   input  logic [31:0]              req_since,
   input  logic                     out_free,
   output logic                     load,
   output shr_pkg::rsp_type         rsp_d,
   output logic                     wr_en,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output logic [31:0]              wr_seq,
   output logic [TIME_BITS-1:0]     wr_time,
   output logic                     rd_en,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic [31:0]              rd_seq,
   input  logic [TIME_BITS-1:0]     rd_time
);

   import shr_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int UW = PW + 1;
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [PW-1:0]     slot_ff, slot_in;
   logic [CW-1:0]     held_ff, held_in;
   logic [31:0]       run_seq_ff, run_seq_in;
   logic [31:0]       since_ff, since_in;
   logic [UW-1:0]     last_ff, last_in;
   logic [UW-1:0]     idx_ff, idx_in;
   logic [UW-1:0]     start_ff, start_in;
   logic              accept;
   logic [31:0]       assigned;
   logic              full;
   logic [UW-1:0]     idx_next;
   logic              at_end;

   function automatic logic [PW-1:0] wrap_idx(input logic [UW-1:0] u);
      logic [UW-1:0] d;
      d = UW'(DEPTH);
      return (u >= d) ? PW'(u - d) : PW'(u);
   endfunction

   assign full      = (held_ff >= CW'(DEPTH));
   assign accept    = req_valid && (state_ff == ST_IDLE) && out_free;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign assigned  = (req_seq != 32'd0) ? req_seq : run_seq_ff;
   assign idx_next  = idx_ff + UW'(1);
   assign at_end    = (idx_next == last_ff);

   always_comb begin
      state_in   = state_ff;
      slot_in    = slot_ff;
      held_in    = held_ff;
      run_seq_in = run_seq_ff;
      since_in   = since_ff;
      last_in    = last_ff;
      idx_in     = idx_ff;
      start_in   = start_ff;
      load       = 1'b0;
      rsp_d      = '0;
      wr_en      = 1'b0;
      wr_addr    = slot_ff;
      wr_seq     = assigned;
      wr_time    = TIME_BITS'(req_time);
      rd_en      = 1'b0;
      rd_addr    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == REQ_RECORD) begin
                  wr_en      = 1'b1;
                  run_seq_in = assigned + 32'd1;
                  held_in    = full ? held_ff : held_ff + CW'(1);
                  slot_in    = (slot_ff == PW'(DEPTH - 1)) ? '0 : slot_ff + PW'(1);
                  load             = 1'b1;
                  rsp_d.entry_seq  = assigned;
                  rsp_d.entry_time = 32'(TIME_BITS'(req_time));
                  rsp_d.fill_count = 7'(held_in);
                  rsp_d.write_slot = 6'(slot_in);
                  rsp_d.is_last    = 1'b1;
               end else if (held_ff == '0) begin
                  load             = 1'b1;
                  rsp_d.fill_count = 7'(held_ff);
                  rsp_d.write_slot = 6'(slot_ff);
                  rsp_d.is_last    = 1'b1;
                  rsp_d.is_empty   = 1'b1;
               end else begin
                  since_in = req_since;
                  idx_in   = full ? UW'(slot_ff) : '0;
                  last_in  = full ? UW'(slot_ff) + UW'(DEPTH) : UW'(held_ff);
                  rd_en    = 1'b1;
                  rd_addr  = wrap_idx(idx_in);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (since_ff < rd_seq) begin
               start_in = idx_ff;
               state_in = ST_EMIT;
            end else if (at_end) begin
               if (out_free) begin
                  load             = 1'b1;
                  rsp_d.fill_count = 7'(held_ff);
                  rsp_d.write_slot = 6'(slot_ff);
                  rsp_d.is_last    = 1'b1;
                  rsp_d.is_empty   = 1'b1;
                  state_in         = ST_IDLE;
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = wrap_idx(idx_next);
               idx_in  = idx_next;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load             = 1'b1;
               rsp_d.entry_seq  = rd_seq;
               rsp_d.entry_time = 32'(rd_time);
               rsp_d.entry_pos  = 6'(idx_ff - start_ff);
               rsp_d.run_length = 7'(last_ff - start_ff);
               rsp_d.run_start  = 7'(start_ff);
               rsp_d.fill_count = 7'(held_ff);
               rsp_d.write_slot = 6'(slot_ff);
               rsp_d.is_last    = at_end;
               if (at_end) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = wrap_idx(idx_next);
                  idx_in  = idx_next;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         slot_ff    <= '0;
         held_ff    <= '0;
         run_seq_ff <= '0;
      end else begin
         state_ff   <= state_in;
         slot_ff    <= slot_in;
         held_ff    <= held_in;
         run_seq_ff <= run_seq_in;
      end
   end

   always_ff @(posedge clock) begin
      since_ff <= since_in;
      last_ff  <= last_in;
      idx_ff   <= idx_in;
      start_ff <= start_in;
   end

   `SHR_ASSERT(a_held_max, held_ff <= CW'(DEPTH), "fill count above depth")
   `SHR_ASSERT(a_load_free, load |-> out_free, "result loaded over a stalled result")
   `SHR_ASSERT(a_emit_range, (state_ff == ST_EMIT) |-> (idx_ff >= start_ff && idx_ff < last_ff), "emit index outside run")
   `SHR_ASSERT_NEXT(a_busy_hold, state_ff != ST_IDLE, $stable(slot_ff) && $stable(held_ff), "ring moved during read")

endmodule

// ===== sv/sequenced_history_ring_top.sv =====
// channel | ports                                  | direction
// req     | req_valid req_stall req_type req_*      | in, one record or read
// rsp     | rsp_valid rsp_stall rsp_*               | out, one or more results
// record: back-to-back records at one per cycle while the result output is not stalled
// read: issued, then store entries are scanned up to the first newer entry, then
// each entry from there on is emitted; entries are read one at a time through the single
// store read port
// reset is synchronous and empties the ring; store contents are not cleared
// a stalled result holds in the output register and stalls the sequencer
// depends on shr_pkg, shr_mem and shr_ctrl
module sequenced_history_ring_top #(
   parameter int DEPTH     = 64,
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [31:0] req_time_value,
   input  logic [31:0] req_seq_value,
   input  logic [31:0] req_since_seqnum,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_entry_seq,
   output logic [31:0] rsp_entry_time,
   output logic [5:0]  rsp_entry_pos,
   output logic [6:0]  rsp_run_length,
   output logic [6:0]  rsp_run_start,
   output logic [6:0]  rsp_fill_count,
   output logic [5:0]  rsp_write_slot,
   output logic        rsp_is_last,
   output logic        rsp_is_empty
);

   import shr_pkg::*;

   localparam int PW = $clog2(DEPTH);

   logic                 out_free;
   logic                 load;
   rsp_type              rsp_d;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 wr_en;
   logic [PW-1:0]        wr_addr;
   logic [31:0]          wr_seq;
   logic [TIME_BITS-1:0] wr_time;
   logic                 rd_en;
   logic [PW-1:0]        rd_addr;
   logic [31:0]          rd_seq;
   logic [TIME_BITS-1:0] rd_time;

   shr_mem #(
      .DEPTH     (DEPTH),
      .TIME_BITS (TIME_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_seq  (wr_seq),
      .wr_time (wr_time),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_seq  (rd_seq),
      .rd_time (rd_time)
   );

   shr_ctrl #(
      .DEPTH     (DEPTH),
      .TIME_BITS (TIME_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_type),
      .req_time  (req_time_value),
      .req_seq   (req_seq_value),
      .req_since (req_since_seqnum),
      .out_free  (out_free),
      .load      (load),
      .rsp_d     (rsp_d),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_seq    (wr_seq),
      .wr_time   (wr_time),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_seq    (rd_seq),
      .rd_time   (rd_time)
   );

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_d;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_entry_seq  = rsp_ff.entry_seq;
   assign rsp_entry_time = rsp_ff.entry_time;
   assign rsp_entry_pos  = rsp_ff.entry_pos;
   assign rsp_run_length = rsp_ff.run_length;
   assign rsp_run_start  = rsp_ff.run_start;
   assign rsp_fill_count = rsp_ff.fill_count;
   assign rsp_write_slot = rsp_ff.write_slot;
   assign rsp_is_last    = rsp_ff.is_last;
   assign rsp_is_empty   = rsp_ff.is_empty;

endmodule

// ===== tb/tb_sequenced_history_ring_top.sv =====
// self-checking testbench for sequenced_history_ring_top: directed and random records and reads
// checked against a cycle-free ring predictor; depends on shr_pkg and the rtl only
module tb_sequenced_history_ring_top;
   timeunit 1ns;
   timeprecision 1ps;
   import shr_pkg::*;

   localparam int DEPTH        = 64;
   localparam int TIME_BITS    = 32;
   localparam int RESET_CYCLES = 8;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 20;
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int MAX_REPORTS  = 10;

   typedef enum {SINCE_GIVEN, SINCE_AT_ENTRY, SINCE_BELOW_ENTRY} since_pick_type;

   typedef struct {
      req_kind_type   kind;
      logic [31:0]    stamp;
      logic [31:0]    seq;
      logic [31:0]    since;
      since_pick_type pick;
   } ring_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = 1'b0;
   logic [31:0] req_time_value = '0;
   logic [31:0] req_seq_value = '0;
   logic [31:0] req_since_seqnum = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_entry_seq;
   logic [31:0] rsp_entry_time;
   logic [5:0]  rsp_entry_pos;
   logic [6:0]  rsp_run_length;
   logic [6:0]  rsp_run_start;
   logic [6:0]  rsp_fill_count;
   logic [5:0]  rsp_write_slot;
   logic        rsp_is_last;
   logic        rsp_is_empty;

   // predicted ring contents and pointers
   logic [31:0] ring_seq [DEPTH];
   logic [31:0] ring_stamp [DEPTH];
   logic [5:0]  next_slot = '0;
   logic [6:0]  held = '0;
   logic [31:0] running_seq = '0;

   ring_request_type request_queue[$];
   rsp_type          expected_entries[$];
   ring_request_type presented;
   int               send_gap = 0;
   int               hold_left = 0;
   int               hold_asked = 0;
   int               hold_served = 0;
   bit               quiet_phase = 1'b0;
   int               mismatch_count = 0;
   longint           cycle_count = 0;

   sequenced_history_ring_top #(
      .DEPTH     (DEPTH),
      .TIME_BITS (TIME_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_time_value   (req_time_value),
      .req_seq_value    (req_seq_value),
      .req_since_seqnum (req_since_seqnum),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_entry_seq    (rsp_entry_seq),
      .rsp_entry_time   (rsp_entry_time),
      .rsp_entry_pos    (rsp_entry_pos),
      .rsp_run_length   (rsp_run_length),
      .rsp_run_start    (rsp_run_start),
      .rsp_fill_count   (rsp_fill_count),
      .rsp_write_slot   (rsp_write_slot),
      .rsp_is_last      (rsp_is_last),
      .rsp_is_empty     (rsp_is_empty)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   function automatic rsp_type ring_entry(logic [31:0] seq, logic [31:0] stamp, int pos,
                                          int len, int start, bit last, bit empty);
      rsp_type e;
      e.entry_seq  = seq;
      e.entry_time = stamp;
      e.entry_pos  = pos[5:0];
      e.run_length = len[6:0];
      e.run_start  = start[6:0];
      e.fill_count = held;
      e.write_slot = next_slot;
      e.is_last    = last;
      e.is_empty   = empty;
      return e;
   endfunction

   // advance the predicted ring by one accepted transaction
   task automatic predict_ring_item(ring_request_type it);
      int first;
      int stop;
      int start;
      bit found;
      if (it.kind == REQ_RECORD) begin
         if (it.seq != 0) running_seq = it.seq;
         ring_seq[next_slot]   = running_seq;
         ring_stamp[next_slot] = it.stamp;
         if (held < DEPTH) held++;
         next_slot = (next_slot == DEPTH - 1) ? '0 : next_slot + 1'b1;
         expected_entries.push_back(ring_entry(running_seq, it.stamp, 0, 0, 0, 1'b1, 1'b0));
         running_seq = running_seq + 1;
      end else begin
         if (held < DEPTH) begin
            first = 0;
            stop  = held;
         end else begin
            first = next_slot;
            stop  = next_slot + DEPTH;
         end
         found = 1'b0;
         start = 0;
         for (int i = first; i < stop && !found; i++) begin
            if (it.since < ring_seq[i % DEPTH]) begin
               found = 1'b1;
               start = i;
            end
         end
         if (found) begin
            for (int k = 0; k < stop - start; k++)
               expected_entries.push_back(ring_entry(ring_seq[(start + k) % DEPTH],
                  ring_stamp[(start + k) % DEPTH], k, stop - start, start,
                  k + 1 == stop - start, 1'b0));
         end else begin
            expected_entries.push_back(ring_entry('0, '0, 0, 0, 0, 1'b1, 1'b1));
         end
      end
   endtask

   function automatic logic [31:0] pick_since(since_pick_type pick, logic [31:0] given);
      int slot;
      if (held == 0 || pick == SINCE_GIVEN) return given;
      slot = $urandom_range(0, held - 1);
      if (pick == SINCE_BELOW_ENTRY) return ring_seq[slot] - 1;
      return ring_seq[slot];
   endfunction

   function automatic ring_request_type record_item(logic [31:0] seq, logic [31:0] stamp);
      ring_request_type it;
      it.kind  = REQ_RECORD;
      it.stamp = stamp;
      it.seq   = seq;
      it.since = $urandom;
      it.pick  = SINCE_GIVEN;
      return it;
   endfunction

   function automatic ring_request_type read_item(since_pick_type pick, logic [31:0] since);
      ring_request_type it;
      it.kind  = REQ_READ;
      it.stamp = $urandom;
      it.seq   = $urandom;
      it.since = since;
      it.pick  = pick;
      return it;
   endfunction

   function automatic ring_request_type random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return record_item(($urandom_range(0, 9) == 0) ? $urandom : 32'd0, $urandom);
      r = $urandom_range(0, 99);
      if (r < 50) return read_item(SINCE_AT_ENTRY, $urandom);
      if (r < 65) return read_item(SINCE_BELOW_ENTRY, $urandom);
      if (r < 80) return read_item(SINCE_GIVEN, $urandom);
      if (r < 90) return read_item(SINCE_GIVEN, 32'd0);
      return read_item(SINCE_GIVEN, 32'hFFFF_FFFF);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_ring_item(presented);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (request_queue.size() > 0) begin
               presented = request_queue.pop_front();
               if (presented.kind == REQ_READ)
                  presented.since = pick_since(presented.pick, presented.since);
               req_valid        <= 1'b1;
               req_type         <= presented.kind;
               req_time_value   <= presented.stamp;
               req_seq_value    <= presented.seq;
               req_since_seqnum <= presented.since;
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_left == 0) begin
            if (hold_served != hold_asked) begin
               hold_served = hold_asked;
               hold_left   = LONG_HOLD;
            end else if ($urandom_range(0, 3) == 0) begin
               hold_left = pick_gap();
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_type got;
      rsp_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_entry_seq, rsp_entry_time, rsp_entry_pos, rsp_run_length, rsp_run_start,
                 rsp_fill_count, rsp_write_slot, rsp_is_last, rsp_is_empty};
         if (expected_entries.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected transaction: seq %h time %h pos %0d len %0d start %0d",
                        got.entry_seq, got.entry_time, got.entry_pos, got.run_length,
                        got.run_start);
         end else begin
            exp = expected_entries.pop_front();
            if (got.entry_seq !== exp.entry_seq || got.entry_time !== exp.entry_time ||
                got.entry_pos !== exp.entry_pos || got.run_length !== exp.run_length ||
                got.run_start !== exp.run_start || got.fill_count !== exp.fill_count ||
                got.write_slot !== exp.write_slot || got.is_last !== exp.is_last ||
                got.is_empty !== exp.is_empty) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("mismatch exp: seq %h time %h pos %0d len %0d start %0d",
                           exp.entry_seq, exp.entry_time, exp.entry_pos, exp.run_length,
                           exp.run_start);
                  $display("              fill %0d slot %0d last %b empty %b",
                           exp.fill_count, exp.write_slot, exp.is_last, exp.is_empty);
                  $display("         got: seq %h time %h pos %0d len %0d start %0d",
                           got.entry_seq, got.entry_time, got.entry_pos, got.run_length,
                           got.run_start);
                  $display("              fill %0d slot %0d last %b empty %b",
                           got.fill_count, got.write_slot, got.is_last, got.is_empty);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic wait_drained();
      while (request_queue.size() != 0 || req_valid || expected_entries.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: empty ring, time extremes, running number wrap, query extremes
      request_queue.push_back(read_item(SINCE_GIVEN, 32'd0));
      request_queue.push_back(record_item(32'd0, 32'd0));
      request_queue.push_back(record_item(32'd0, 32'hFFFF_FFFF));
      request_queue.push_back(read_item(SINCE_GIVEN, 32'd0));
      request_queue.push_back(read_item(SINCE_GIVEN, 32'hFFFF_FFFF));
      request_queue.push_back(record_item(32'hFFFF_FFFF, 32'hA5A5_A5A5));
      request_queue.push_back(record_item(32'd0, 32'h5A5A_5A5A));
      request_queue.push_back(record_item(32'd1, 32'd1));
      request_queue.push_back(read_item(SINCE_GIVEN, 32'd0));
      request_queue.push_back(read_item(SINCE_GIVEN, 32'hFFFF_FFFE));
      request_queue.push_back(read_item(SINCE_AT_ENTRY, 32'd0));
      request_queue.push_back(read_item(SINCE_BELOW_ENTRY, 32'd0));
      request_queue.push_back(record_item(32'h8000_0000, 32'h8000_0000));
      request_queue.push_back(record_item(32'h7FFF_FFFF, 32'h7FFF_FFFF));
      request_queue.push_back(read_item(SINCE_GIVEN, 32'h7FFF_FFFF));
      request_queue.push_back(read_item(SINCE_GIVEN, 32'h8000_0000));
      wait_drained();

      // back-to-back stretch with no idling on either side
      @(negedge clock);
      quiet_phase = 1'b1;
      repeat (60) request_queue.push_back(random_item());
      wait_drained();
      quiet_phase = 1'b0;

      repeat (120) request_queue.push_back(random_item());

      // long receiver hold while records keep coming
      repeat (40) request_queue.push_back(record_item(32'd0, $urandom));
      @(negedge clock);
      hold_asked++;
      wait_drained();

      repeat (175) request_queue.push_back(random_item());
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_entries.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
